FILE: rtl/core/mbsa_pkg.sv
// Constants, types and codes shared by the multilevel bitmap slot allocator.
package mbsa_pkg;

    localparam int LEVELS      = 2;
    localparam int TABLE_BITS  = 6;
    localparam int FANOUT      = TABLE_BITS - 1;
    localparam int USED_LEVELS = (LEVELS > 2) ? 2 : LEVELS;

    localparam int SLOT_W = 10;
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    localparam int L0_BITS  = (FANOUT > SLOT_W) ? SLOT_W : FANOUT;
    localparam int L1_BITS  = (2 * FANOUT > SLOT_W) ? SLOT_W : 2 * FANOUT;
    localparam int L0_SLOTS = 1 << L0_BITS;
    localparam int L1_SLOTS = 1 << L1_BITS;
    localparam int L0_WORDS = (L0_SLOTS + WORD_W - 1) / WORD_W;
    localparam int L1_WORDS = (L1_SLOTS + WORD_W - 1) / WORD_W;

    localparam int MAP_WORDS = L0_WORDS + ((USED_LEVELS >= 2) ? L1_WORDS : 0);
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAP_WORDS - 1);
    localparam logic [ADDR_W-1:0] L1_BASE   = ADDR_W'(L0_WORDS);

    localparam logic [SLOT_W-1:0] L0_IDX_MASK = SLOT_W'(L0_SLOTS - 1);
    localparam logic [SLOT_W-1:0] L1_IDX_MASK = SLOT_W'(L1_SLOTS - 1);

    localparam logic [WORD_W-1:0] L0_AVAIL =
        (L0_SLOTS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << L0_SLOTS) - 64'd1);
    localparam logic [WORD_W-1:0] L1_AVAIL =
        (L1_SLOTS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << L1_SLOTS) - 64'd1);

    localparam logic [WORD_W-1:0] RESET_WORD0 = WORD_W'(1);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FREE = 3'b100
    } state_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } find_t;

endpackage

FILE: rtl/core/multilevel_bitmap_slot_allocator.sv
// Top level: multilevel first-fit bitmap slot allocator with one bitmap memory.
// Allocate: accept, then scan the bitmap words in order with a read prefetched one
// word ahead; up to MAP_WORDS (33) words are scanned.
// Free: accept, then a read-modify-write of the word. One transaction at a time.
// Reset clears control and valid bits; an unwritten word reads as its reset value.
module multilevel_bitmap_slot_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] func, [1] free_level, [11:2] free_index
    input  logic [mbsa_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] status, [1] got_level, [11:2] got_index
    output logic [mbsa_pkg::M_DATA_W-1:0] m_tdata
);
    import mbsa_pkg::*;

    logic [WORD_W-1:0] map_mem [MAP_WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic [MAP_WORDS-1:0] vld_reg, vld_next;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] rd_addr;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic              skip_reg, skip_next;

    logic              m_valid_reg, m_valid_next;
    logic              status_reg, status_next;
    logic              level_reg, level_next;
    logic [SLOT_W-1:0] index_reg, index_next;

    logic              wr_en;
    logic [WORD_W-1:0] wr_data;

    logic              in_accept;
    logic              in_func, in_level;
    logic [SLOT_W-1:0] in_index, in_masked;
    logic [SLOT_W-BIT_W-1:0] in_woff;
    logic [ADDR_W-1:0] free_addr;

    logic [WORD_W-1:0] cur_word;
    logic              is_l1;
    logic [ADDR_W-1:0] word_off;
    logic [WORD_W-1:0] avail;
    find_t             find;
    logic [ADDR_W+BIT_W-1:0] idx_wide;

    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;
    assign in_func   = s_tdata[0];
    assign in_level  = s_tdata[1];
    assign in_index  = s_tdata[SLOT_W+1:2];
    assign in_masked = in_index & (in_level ? L1_IDX_MASK : L0_IDX_MASK);
    assign in_woff   = in_masked[SLOT_W-1:BIT_W];
    assign free_addr = in_level ? ADDR_W'(L0_WORDS + 32'(in_woff)) : ADDR_W'(in_woff);

    assign cur_word = vld_reg[addr_reg] ? rdata_reg
                                        : ((addr_reg == '0) ? RESET_WORD0 : '0);
    assign is_l1    = (32'(addr_reg) >= L0_WORDS);
    assign word_off = is_l1 ? (addr_reg - L1_BASE) : addr_reg;
    assign avail    = is_l1 ? L1_AVAIL : L0_AVAIL;
    assign idx_wide = {word_off, find.pos};

    mbsa_find_clear u_find (
        .word   (cur_word),
        .avail  (avail),
        .result (find)
    );

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        bit_next     = bit_reg;
        skip_next    = skip_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        level_next   = level_reg;
        index_next   = index_reg;
        vld_next     = vld_reg;
        wr_en        = 1'b0;
        wr_data      = cur_word;
        rd_addr      = addr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_func == FUNC_FREE) begin
                    rd_addr = free_addr;
                end else begin
                    rd_addr = '0;
                end
                if (in_accept) begin
                    bit_next  = in_masked[BIT_W-1:0];
                    skip_next = in_level && (USED_LEVELS < 2);
                    if (in_func == FUNC_FREE) begin
                        addr_next  = free_addr;
                        state_next = ST_FREE;
                    end else begin
                        addr_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_addr = (addr_reg == ADDR_LAST) ? addr_reg : addr_reg + ADDR_W'(1);
                if (find.found) begin
                    wr_en        = 1'b1;
                    wr_data      = cur_word | (WORD_W'(1) << find.pos);
                    m_valid_next = 1'b1;
                    status_next  = STATUS_OK;
                    level_next   = is_l1;
                    index_next   = SLOT_W'(idx_wide);
                    state_next   = ST_IDLE;
                end else if (addr_reg == ADDR_LAST) begin
                    m_valid_next = 1'b1;
                    status_next  = STATUS_FULL;
                    level_next   = 1'b0;
                    index_next   = '0;
                    state_next   = ST_IDLE;
                end else begin
                    addr_next = rd_addr;
                end
            end
            ST_FREE: begin
                wr_en        = !skip_reg;
                wr_data      = cur_word & ~(WORD_W'(1) << bit_reg);
                m_valid_next = 1'b1;
                status_next  = STATUS_OK;
                level_next   = 1'b0;
                index_next   = '0;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en) begin
            vld_next[addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= map_mem[rd_addr];
        if (wr_en) begin
            map_mem[addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        bit_reg    <= bit_next;
        skip_reg   <= skip_next;
        status_reg <= status_next;
        level_reg  <= level_next;
        index_reg  <= index_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - SLOT_W - 2){1'b0}}, index_reg, level_reg, status_reg};

endmodule

FILE: rtl/core/mbsa_find_clear.sv
// Priority encoder: lowest clear bit of a bitmap word among the available bits.
module mbsa_find_clear (
    input  logic [mbsa_pkg::WORD_W-1:0] word,
    input  logic [mbsa_pkg::WORD_W-1:0] avail,
    output mbsa_pkg::find_t             result
);
    import mbsa_pkg::*;

    logic [WORD_W-1:0] open_bits;

    assign open_bits = ~word & avail;

    always_comb begin
        result = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (open_bits[i]) begin
                result.found = 1'b1;
                result.pos   = BIT_W'(i);
            end
        end
    end

endmodule
